// ----- hdl/assert_macros.svh -----
// Assertion macros for the blend pipeline.
// The synthesis build defines SYNTH and gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/cabo_pkg.sv -----
package cabo_pkg;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_X_OFFSET     = 2'd0;
    localparam t_cfg_idx CFG_Y_OFFSET     = 2'd1;
    localparam t_cfg_idx CFG_UPPER_WIDTH  = 2'd2;
    localparam t_cfg_idx CFG_UPPER_HEIGHT = 2'd3;

    // Geometry registers
    typedef struct packed {
        logic signed [12:0] x_offset;
        logic signed [12:0] y_offset;
        logic [12:0]        upper_width;
        logic [12:0]        upper_height;
    } t_cfg;

    // Incoming pixel item
    typedef struct packed {
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [7:0]  lower_a;
        logic [7:0]  lower_r;
        logic [7:0]  lower_g;
        logic [7:0]  lower_b;
        logic [7:0]  upper_a;
        logic [7:0]  upper_r;
        logic [7:0]  upper_g;
        logic [7:0]  upper_b;
    } t_pix;

    // After offset subtraction and channel differences
    typedef struct packed {
        logic signed [13:0] rx;
        logic signed [13:0] ry;
        logic [7:0]         lower_a;
        logic [7:0]         lower_r;
        logic [7:0]         lower_g;
        logic [7:0]         lower_b;
        logic [7:0]         upper_a;
        logic [7:0]         inv_ua;
        logic [7:0]         inv_la;
        logic signed [8:0]  dr;
        logic signed [8:0]  dg;
        logic signed [8:0]  db;
    } t_s1;

    // After coverage test and products
    typedef struct packed {
        logic               blend;
        logic               ua_nz;
        logic [7:0]         lower_a;
        logic [7:0]         lower_r;
        logic [7:0]         lower_g;
        logic [7:0]         lower_b;
        logic [15:0]        pa;
        logic signed [16:0] pr;
        logic signed [16:0] pg;
        logic signed [16:0] pb;
    } t_s2;

    // Result item
    typedef struct packed {
        logic [7:0] out_a;
        logic [7:0] out_r;
        logic [7:0] out_g;
        logic [7:0] out_b;
        logic       was_blended;
    } t_res;

endpackage

// ----- hdl/cabo_prep.sv -----
module cabo_prep (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cabo_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  cabo_pkg::t_pix i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output cabo_pkg::t_s1  o_data
);
    import cabo_pkg::*;

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;

    always_comb begin
        n_data.rx = $signed({2'b00, i_data.pos_x})
                  - $signed({i_cfg.x_offset[12], i_cfg.x_offset});
        n_data.ry = $signed({2'b00, i_data.pos_y})
                  - $signed({i_cfg.y_offset[12], i_cfg.y_offset});
        n_data.lower_a = i_data.lower_a;
        n_data.lower_r = i_data.lower_r;
        n_data.lower_g = i_data.lower_g;
        n_data.lower_b = i_data.lower_b;
        n_data.upper_a = i_data.upper_a;
        n_data.inv_ua  = 8'd255 - i_data.upper_a;
        n_data.inv_la  = 8'd255 - i_data.lower_a;
        n_data.dr = $signed({1'b0, i_data.upper_r}) - $signed({1'b0, i_data.lower_r});
        n_data.dg = $signed({1'b0, i_data.upper_g}) - $signed({1'b0, i_data.lower_g});
        n_data.db = $signed({1'b0, i_data.upper_b}) - $signed({1'b0, i_data.lower_b});
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ----- hdl/cabo_mul.sv -----
module cabo_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cabo_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  cabo_pkg::t_s1  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output cabo_pkg::t_s2  o_data
);
    import cabo_pkg::*;

    logic               r_valid;
    t_s2                r_data;
    t_s2                n_data;
    logic               covered;
    logic signed [8:0]  alpha_s;
    logic signed [17:0] full_r;
    logic signed [17:0] full_g;
    logic signed [17:0] full_b;

    always_comb begin
        covered = (i_data.rx >= 14'sd0) && (i_data.ry >= 14'sd0)
               && (i_data.rx < $signed({1'b0, i_cfg.upper_width}))
               && (i_data.ry < $signed({1'b0, i_cfg.upper_height}));
        alpha_s = $signed({1'b0, i_data.upper_a});
        full_r  = i_data.dr * alpha_s;
        full_g  = i_data.dg * alpha_s;
        full_b  = i_data.db * alpha_s;
        n_data.ua_nz   = (i_data.upper_a != 8'd0);
        n_data.blend   = covered && n_data.ua_nz;
        n_data.lower_a = i_data.lower_a;
        n_data.lower_r = i_data.lower_r;
        n_data.lower_g = i_data.lower_g;
        n_data.lower_b = i_data.lower_b;
        n_data.pa      = i_data.inv_ua * i_data.inv_la;
        // |product| <= 65025, so 17 signed bits hold it
        n_data.pr      = full_r[16:0];
        n_data.pg      = full_g[16:0];
        n_data.pb      = full_b[16:0];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ----- hdl/cabo_mix.sv -----
module cabo_mix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cabo_pkg::t_s2  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output cabo_pkg::t_res o_data
);
    import cabo_pkg::*;

    logic        r_valid;
    t_res        r_data;
    t_res        n_data;
    logic [15:0] a_sum;

    always_comb begin
        // max 65025 + 255 fits 16 bits
        a_sum = i_data.pa + 16'd255;
        n_data.was_blended = i_data.blend;
        if (i_data.blend) begin
            n_data.out_a = 8'd255 - a_sum[15:8];
            // floor(p / 256) mod 256 is bits 15:8
            n_data.out_r = i_data.lower_r + i_data.pr[15:8];
            n_data.out_g = i_data.lower_g + i_data.pg[15:8];
            n_data.out_b = i_data.lower_b + i_data.pb[15:8];
        end else begin
            n_data.out_a = i_data.lower_a;
            n_data.out_r = i_data.lower_r;
            n_data.out_g = i_data.lower_g;
            n_data.out_b = i_data.lower_b;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ----- hdl/clipped_alpha_blend_onto_lower.sv -----
// Clipped alpha blend of an upper ARGB32 image onto a lower one.
// Input channel (i_valid / o_ready): one lower pixel per item, with its
// coordinates, its four channels and the upper pixel lying over it.
// Output channel (o_valid / i_ready): one result item per input item, in
// order: the composited pixel and a flag saying whether it was blended.
// Configuration: i_cfg_we writes i_cfg_data into the register picked by
// i_cfg_idx (x offset, y offset, upper width, upper height); write only
// while no item is in flight.
// An accepted item is registered by each stage in turn; o_valid rises once
// the last stage holds it. Throughput is one item per cycle while i_ready
// stays high, set by the three register stages (offset subtract,
// coverage compare and multiplies, shift/add and select).
// Each stage has its own valid bit and takes a new item when empty or when
// its successor moves, so bubbles close up while the receiver stalls; with
// all three stages full and i_ready low, o_ready drops and nothing moves.
// Reset (synchronous, active low) empties the pipeline and clears the
// geometry registers to zero, so nothing is covered until they are set.
`include "assert_macros.svh"

module clipped_alpha_blend_onto_lower (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  cabo_pkg::t_cfg_idx i_cfg_idx,
    input  logic [12:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [11:0]        i_pos_x,
    input  logic [11:0]        i_pos_y,
    input  logic [7:0]         i_lower_a,
    input  logic [7:0]         i_lower_r,
    input  logic [7:0]         i_lower_g,
    input  logic [7:0]         i_lower_b,
    input  logic [7:0]         i_upper_a,
    input  logic [7:0]         i_upper_r,
    input  logic [7:0]         i_upper_g,
    input  logic [7:0]         i_upper_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_out_a,
    output logic [7:0]         o_out_r,
    output logic [7:0]         o_out_g,
    output logic [7:0]         o_out_b,
    output logic               o_was_blended
);
    import cabo_pkg::*;

    t_cfg r_cfg;
    t_pix pix;
    t_s1  s1_data;
    t_s2  s2_data;
    t_res res;
    logic s1_valid;
    logic s1_ready;
    logic s2_valid;
    logic s2_ready;

    // Geometry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_X_OFFSET:     r_cfg.x_offset     <= $signed(i_cfg_data);
                CFG_Y_OFFSET:     r_cfg.y_offset     <= $signed(i_cfg_data);
                CFG_UPPER_WIDTH:  r_cfg.upper_width  <= i_cfg_data;
                CFG_UPPER_HEIGHT: r_cfg.upper_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        pix.pos_x   = i_pos_x;
        pix.pos_y   = i_pos_y;
        pix.lower_a = i_lower_a;
        pix.lower_r = i_lower_r;
        pix.lower_g = i_lower_g;
        pix.lower_b = i_lower_b;
        pix.upper_a = i_upper_a;
        pix.upper_r = i_upper_r;
        pix.upper_g = i_upper_g;
        pix.upper_b = i_upper_b;
    end

    // Stage 1: position relative to the upper image, channel differences
    cabo_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (pix),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    // Stage 2: rectangle test, alpha and colour products
    cabo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    // Stage 3: scale back, add to lower, choose blend or pass-through
    cabo_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (res)
    );

    assign o_out_a       = res.out_a;
    assign o_out_r       = res.out_r;
    assign o_out_g       = res.out_g;
    assign o_out_b       = res.out_b;
    assign o_was_blended = res.was_blended;

    // A stage-2 item blocked by a full output stage is still there next cycle
    `ASSERT_NXT(a_s2_held, i_clk, i_rst_n, s2_valid && !s2_ready, s2_valid)
    // A stage-2 item moving on shows up as a result next cycle
    `ASSERT_NXT(a_s2_moves, i_clk, i_rst_n, s2_valid && s2_ready, o_valid)
    // Zero upper alpha gives zero colour products and no blend
    `ASSERT_IMP(a_zero_alpha, i_clk, i_rst_n, s2_valid && !s2_data.ua_nz,
        s2_data.pr == 17'sd0 && s2_data.pg == 17'sd0 && s2_data.pb == 17'sd0 && !s2_data.blend)

endmodule

// ----- tb/clipped_alpha_blend_onto_lower_tb.sv -----
`timescale 1ns / 100ps

// Holds the geometry copy and the composites still owed by the block.
class blend_scoreboard;
    int             x_off;
    int             y_off;
    int             up_w;
    int             up_h;
    cabo_pkg::t_res composites_due[$];
    int             failures;

    function new();
        x_off    = 0;
        y_off    = 0;
        up_w     = 0;
        up_h     = 0;
        failures = 0;
    endfunction

    function void set_geometry(cabo_pkg::t_cfg_idx idx, logic [12:0] data);
        case (idx)
            cabo_pkg::CFG_X_OFFSET:     x_off = $signed(data);
            cabo_pkg::CFG_Y_OFFSET:     y_off = $signed(data);
            cabo_pkg::CFG_UPPER_WIDTH:  up_w  = data;
            cabo_pkg::CFG_UPPER_HEIGHT: up_h  = data;
        endcase
    endfunction

    // l + floor((u - l) * a / 256); >>> on a signed int floors
    function logic [7:0] mix_channel(int l, int u, int a);
        int sum;
        sum = l + (((u - l) * a) >>> 8);
        return sum[7:0];
    endfunction

    function cabo_pkg::t_res blend_pixel(cabo_pkg::t_pix p);
        int             rx;
        int             ry;
        int             ua;
        int             la;
        int             alpha;
        cabo_pkg::t_res r;
        rx = p.pos_x;
        rx = rx - x_off;
        ry = p.pos_y;
        ry = ry - y_off;
        ua = p.upper_a;
        la = p.lower_a;
        if (rx >= 0 && ry >= 0 && rx < up_w && ry < up_h && ua != 0) begin
            alpha         = 255 - (((255 - ua) * (255 - la) + 255) >> 8);
            r.out_a       = alpha[7:0];
            r.out_r       = mix_channel(p.lower_r, p.upper_r, ua);
            r.out_g       = mix_channel(p.lower_g, p.upper_g, ua);
            r.out_b       = mix_channel(p.lower_b, p.upper_b, ua);
            r.was_blended = 1'b1;
        end else begin
            r.out_a       = p.lower_a;
            r.out_r       = p.lower_r;
            r.out_g       = p.lower_g;
            r.out_b       = p.lower_b;
            r.was_blended = 1'b0;
        end
        return r;
    endfunction

    function void note_pixel(cabo_pkg::t_pix p);
        composites_due.push_back(blend_pixel(p));
    endfunction

    function void check_result(cabo_pkg::t_res got);
        cabo_pkg::t_res want;
        if (composites_due.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected item: a=%h r=%h g=%h b=%h blended=%b",
                         got.out_a, got.out_r, got.out_g, got.out_b, got.was_blended);
        end else begin
            want = composites_due.pop_front();
            if (got.out_a !== want.out_a || got.out_r !== want.out_r ||
                got.out_g !== want.out_g || got.out_b !== want.out_b ||
                got.was_blended !== want.was_blended) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: expected a=%h r=%h g=%h b=%h blended=%b",
                             want.out_a, want.out_r, want.out_g, want.out_b,
                             want.was_blended);
                    $display("          got      a=%h r=%h g=%h b=%h blended=%b",
                             got.out_a, got.out_r, got.out_g, got.out_b,
                             got.was_blended);
                end
            end
        end
    endfunction
endclass

module clipped_alpha_blend_onto_lower_tb;
    import cabo_pkg::*;

    // Cycles with no item moving on either side before the run is abandoned.
    // Worst honest case: the long receiver hold-off plus a fully stalled
    // receiver segment plus a sender gap, well under this.
    localparam int STALL_LIMIT     = 3000;
    localparam int ITEMS_PER_PHASE = 205;
    // Long receiver hold-off: starts once this many items have gone in
    localparam int HOLD_AT         = 300;
    localparam int HOLD_CYCLES     = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [12:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        o_valid;
    logic        i_ready;
    t_pix        pix_drv;
    logic [7:0]  o_out_a;
    logic [7:0]  o_out_r;
    logic [7:0]  o_out_g;
    logic [7:0]  o_out_b;
    logic        o_was_blended;

    t_res            res_seen;
    int              pixels_in;
    blend_scoreboard sb;

    clipped_alpha_blend_onto_lower u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pos_x       (pix_drv.pos_x),
        .i_pos_y       (pix_drv.pos_y),
        .i_lower_a     (pix_drv.lower_a),
        .i_lower_r     (pix_drv.lower_r),
        .i_lower_g     (pix_drv.lower_g),
        .i_lower_b     (pix_drv.lower_b),
        .i_upper_a     (pix_drv.upper_a),
        .i_upper_r     (pix_drv.upper_r),
        .i_upper_g     (pix_drv.upper_g),
        .i_upper_b     (pix_drv.upper_b),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_a       (o_out_a),
        .o_out_r       (o_out_r),
        .o_out_g       (o_out_g),
        .o_out_b       (o_out_b),
        .o_was_blended (o_was_blended)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Both handshakes are sampled here, at the rising edge; inputs only
    // ever change at the falling edge, so there is no race.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            sb.note_pixel(pix_drv);
            pixels_in++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            res_seen.out_a       = o_out_a;
            res_seen.out_r       = o_out_r;
            res_seen.out_g       = o_out_g;
            res_seen.out_b       = o_out_b;
            res_seen.was_blended = o_was_blended;
            sb.check_result(res_seen);
        end
    end

    // Watchdog: ends the run if nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Receiver: segments of random length, each with its own stall style
    // (always ready, coin toss, repeating byte pattern, mostly stalled).
    // Once, after HOLD_AT items have gone in, it holds off for HOLD_CYCLES
    // so the three stages fill and o_ready drops while the sender offers.
    initial begin : receiver
        int         seg;
        int         mode;
        int         k;
        logic [7:0] pat;
        bit         held;
        i_ready = 1'b0;
        held    = 1'b0;
        forever begin
            if (!held && pixels_in >= HOLD_AT) begin
                held = 1'b1;
                @(negedge i_clk);
                i_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end
            seg  = $urandom_range(16, 120);
            mode = $urandom_range(0, 3);
            pat  = 8'($urandom);
            for (k = 0; k < seg; k++) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_ready = 1'b1;
                    1:       i_ready = 1'($urandom_range(0, 1));
                    2:       i_ready = pat[k % 8];
                    default: i_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one item and hold it until taken
    task automatic send_pixel(input t_pix p);
        @(negedge i_clk);
        i_valid = 1'b1;
        pix_drv = p;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Sender idles with i_valid low for the gap n; junk on the payload meanwhile
    task automatic sender_gap(input int n);
        @(negedge i_clk);
        i_valid = 1'b0;
        pix_drv = random_pixel();
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Stop offering, wait for every owed composite, then a latency margin
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.composites_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_geometry_reg(input t_cfg_idx idx, input int value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value[12:0];
        sb.set_geometry(idx, value[12:0]);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic apply_geometry(input int xo, input int yo, input int w, input int h);
        write_geometry_reg(CFG_X_OFFSET, xo);
        write_geometry_reg(CFG_Y_OFFSET, yo);
        write_geometry_reg(CFG_UPPER_WIDTH, w);
        write_geometry_reg(CFG_UPPER_HEIGHT, h);
    endtask

    function automatic t_pix make_pixel(input int px, input int py,
                                        input int la, input int lr,
                                        input int lg, input int lb,
                                        input int ua, input int ur,
                                        input int ug, input int ub);
        t_pix p;
        p.pos_x   = px[11:0];
        p.pos_y   = py[11:0];
        p.lower_a = la[7:0];
        p.lower_r = lr[7:0];
        p.lower_g = lg[7:0];
        p.lower_b = lb[7:0];
        p.upper_a = ua[7:0];
        p.upper_r = ur[7:0];
        p.upper_g = ug[7:0];
        p.upper_b = ub[7:0];
        return p;
    endfunction

    // Coordinates cluster on the rectangle edges, clipped to the frame
    function automatic logic [11:0] pick_coord(input int off, input int span);
        int v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 4095);
            1:       v = off - 1 + int'($urandom_range(0, 2));
            2:       v = off + span - 2 + int'($urandom_range(0, 2));
            default: v = off + int'($urandom_range(0, span));
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    // Channel values lean on 0, 1 and 255
    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h01;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_pix random_pixel();
        t_pix p;
        p.pos_x   = pick_coord(sb.x_off, sb.up_w);
        p.pos_y   = pick_coord(sb.y_off, sb.up_h);
        p.lower_a = pick_channel();
        p.lower_r = pick_channel();
        p.lower_g = pick_channel();
        p.lower_b = pick_channel();
        p.upper_a = pick_channel();
        p.upper_r = pick_channel();
        p.upper_g = pick_channel();
        p.upper_b = pick_channel();
        return p;
    endfunction

    // Bursts of random length with random gaps; steady = back to back
    task automatic run_phase(input int n_items, input bit steady);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 32);
            while (burst > 0 && sent < n_items) begin
                send_pixel(random_pixel());
                sent++;
                burst--;
            end
            if (steady || $urandom_range(0, 3) == 0)
                gap = 0;
            else
                gap = $urandom_range(1, 12);
            if (gap > 0)
                sender_gap(gap);
        end
        drain_pipeline();
    endtask

    initial begin : stimulus
        int ph;
        sb         = new();
        pixels_in  = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_X_OFFSET;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        pix_drv    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Geometry still at reset: nothing covered even with full alpha
        send_pixel(make_pixel(0, 0, 1, 2, 3, 4, 255, 200, 100, 50));
        send_pixel(make_pixel(4095, 4095, 255, 255, 255, 255, 255, 0, 0, 0));
        drain_pipeline();

        // Small rectangle: columns 10..25, rows 20..27
        apply_geometry(10, 20, 16, 8);
        // first pixel of a row with zero alpha must pass unchanged
        send_pixel(make_pixel(10, 20, 8'h40, 1, 2, 3, 0, 255, 255, 255));
        send_pixel(make_pixel(10, 20, 0, 0, 0, 0, 255, 255, 255, 255));
        send_pixel(make_pixel(11, 20, 255, 255, 255, 255, 255, 0, 0, 0));
        // last covered pixel, then one step past each edge
        send_pixel(make_pixel(25, 27, 128, 10, 200, 90, 128, 250, 5, 90));
        send_pixel(make_pixel(26, 27, 9, 8, 7, 6, 255, 1, 1, 1));
        send_pixel(make_pixel(9, 20, 9, 8, 7, 6, 255, 1, 1, 1));
        send_pixel(make_pixel(10, 19, 9, 8, 7, 6, 255, 1, 1, 1));
        send_pixel(make_pixel(10, 28, 9, 8, 7, 6, 255, 1, 1, 1));
        // alpha of one and 254: negative differences must floor, not truncate
        send_pixel(make_pixel(12, 22, 255, 255, 128, 0, 1, 0, 0, 255));
        send_pixel(make_pixel(13, 23, 0, 0, 0, 0, 1, 255, 255, 255));
        send_pixel(make_pixel(14, 24, 255, 200, 100, 0, 254, 0, 255, 17));
        // zero alpha in mid-row, then full alpha
        send_pixel(make_pixel(15, 25, 77, 1, 2, 3, 0, 9, 9, 9));
        send_pixel(make_pixel(12, 21, 0, 0, 0, 0, 255, 0, 0, 0));
        // frame corners, all outside
        send_pixel(make_pixel(0, 0, 1, 2, 3, 4, 255, 5, 6, 7));
        send_pixel(make_pixel(4095, 4095, 1, 2, 3, 4, 255, 5, 6, 7));
        send_pixel(make_pixel(4095, 0, 1, 2, 3, 4, 255, 5, 6, 7));
        send_pixel(make_pixel(0, 4095, 1, 2, 3, 4, 255, 5, 6, 7));
        drain_pipeline();

        // Extreme negative offsets, widths beyond the nominal maximum
        apply_geometry(-4096, -4096, 8191, 8191);
        run_phase(ITEMS_PER_PHASE, 1'b0);
        // One-pixel rectangle in the far corner
        apply_geometry(4095, 4095, 1, 1);
        run_phase(ITEMS_PER_PHASE, 1'b0);
        // Whole frame covered, no sender idling
        apply_geometry(0, 0, 4096, 4096);
        run_phase(ITEMS_PER_PHASE, 1'b1);
        // Thin band hanging off the left edge
        apply_geometry(-5, 3000, 4096, 100);
        run_phase(ITEMS_PER_PHASE, 1'b0);
        // Zero width covers nothing
        apply_geometry(100, 0, 0, 4096);
        run_phase(ITEMS_PER_PHASE, 1'b0);
        for (ph = 0; ph < 2; ph++) begin
            apply_geometry(int'($urandom_range(0, 8191)) - 4096,
                           int'($urandom_range(0, 8191)) - 4096,
                           $urandom_range(0, 4096), $urandom_range(0, 4096));
            run_phase(ITEMS_PER_PHASE, 1'b0);
        end

        // Margin for stray results after the last one owed
        repeat (8) @(posedge i_clk);
        if (sb.composites_due.size() != 0) begin
            $display("%0d composites never came out", sb.composites_due.size());
            sb.failures += sb.composites_due.size();
        end
        if (sb.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
